>>> hdl/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define PIPC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define PIPC_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PIPC_ASSERT(lbl, clk, rstn, prop, msg)
`define PIPC_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

>>> hdl/pipc_pkg.sv
// Types and constants of the point-in-convex-polygon block
package pipc_pkg;

  localparam int COORD_W     = 31;
  localparam int DIFF_W      = 32;
  localparam int PROD_W      = 64;
  localparam int CFG_W       = 11;
  localparam int IDX_IN_W    = 10;
  localparam int OP_W        = 1;
  localparam int LOC_W       = 2;
  localparam int MIN_VERTICES = 3;

  localparam logic [OP_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OP_W-1:0] OP_QUERY = 1'b1;

  localparam logic [LOC_W-1:0] LOC_OUTSIDE  = 2'd0;
  localparam logic [LOC_W-1:0] LOC_INSIDE   = 2'd1;
  localparam logic [LOC_W-1:0] LOC_BOUNDARY = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vert_t;

  typedef struct packed {
    logic done;
    logic pos;
    logic zero;
    logic in_box;
  } orient_res_t;

endpackage

>>> hdl/pipc_in_if.sv
// Input channel: load vertex or query point
interface pipc_in_if;
  logic                              valid;
  logic                              ready;
  logic [pipc_pkg::OP_W-1:0]         operation;
  logic [pipc_pkg::IDX_IN_W-1:0]     vertex_index;
  pipc_pkg::coord_t                  x_coord;
  pipc_pkg::coord_t                  y_coord;

  modport source (output valid, operation, vertex_index, x_coord, y_coord, input ready);
  modport sink   (input valid, operation, vertex_index, x_coord, y_coord, output ready);
endinterface

>>> hdl/pipc_out_if.sv
// Result channel: point location
interface pipc_out_if;
  logic                          valid;
  logic                          ready;
  logic [pipc_pkg::LOC_W-1:0]    location;

  modport source (output valid, location, input ready);
  modport sink   (input valid, location, output ready);
endinterface

>>> hdl/pipc_vstore.sv
// Vertex memory: one write port, one registered read port
module pipc_vstore #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  pipc_pkg::vert_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output pipc_pkg::vert_t rd_data
);
  import pipc_pkg::*;

  vert_t mem [DEPTH];
  vert_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/pipc_orient.sv
// Orientation unit: sign of cross(b - a, p - a) on one shared multiplier
module pipc_orient (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  pipc_pkg::vert_t       a,
  input  pipc_pkg::vert_t       b,
  input  pipc_pkg::vert_t       p,
  output pipc_pkg::orient_res_t res
);
  import pipc_pkg::*;

  typedef enum logic [1:0] {
    O_IDLE,
    O_MUL1,
    O_MUL2,
    O_DONE
  } phase_t;

  phase_t phase_r, phase_nxt;
  diff_t  d1x_r, d1y_r, d2x_r, d2y_r;
  prod_t  p1_r, p2_r;
  logic   box_r;
  diff_t  mul_a, mul_b;
  prod_t  mul_out;
  logic   box_nxt;

  assign box_nxt = (a.x <= p.x || b.x <= p.x) && (p.x <= a.x || p.x <= b.x) &&
                   (a.y <= p.y || b.y <= p.y) && (p.y <= a.y || p.y <= b.y);

  // first pass d1x*d2y, second pass d1y*d2x
  assign mul_a   = (phase_r == O_MUL1) ? d1x_r : d1y_r;
  assign mul_b   = (phase_r == O_MUL1) ? d2y_r : d2x_r;
  assign mul_out = mul_a * mul_b;

  always_comb begin
    phase_nxt = phase_r;
    if (start) begin
      phase_nxt = O_MUL1;
    end else begin
      unique case (phase_r)
        O_IDLE: phase_nxt = O_IDLE;
        O_MUL1: phase_nxt = O_MUL2;
        O_MUL2: phase_nxt = O_DONE;
        O_DONE: phase_nxt = O_IDLE;
        default: phase_nxt = O_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= O_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d1x_r <= diff_t'(b.x) - diff_t'(a.x);
      d1y_r <= diff_t'(b.y) - diff_t'(a.y);
      d2x_r <= diff_t'(p.x) - diff_t'(a.x);
      d2y_r <= diff_t'(p.y) - diff_t'(a.y);
      box_r <= box_nxt;
    end
    if (phase_r == O_MUL1) begin
      p1_r <= mul_out;
    end
    if (phase_r == O_MUL2) begin
      p2_r <= mul_out;
    end
  end

  assign res.done   = (phase_r == O_DONE);
  assign res.pos    = (p1_r > p2_r);
  assign res.zero   = (p1_r == p2_r);
  assign res.in_box = box_r;

endmodule

>>> hdl/point_in_convex_polygon.sv
// Point location against a convex polygon held in an on-chip vertex memory.
// in_chan (valid/ready) carries load and query items; a transfer happens when
// valid and ready are both high. A load writes one vertex (slot at or beyond
// MAX_VERTICES is dropped) and gives no result. A query
// gives one transfer on out_chan with the location: outside, inside, boundary.
// cfg_we/cfg_wdata set the vertex count, clamped to 3..MAX_VERTICES; write it
// only while the block is idle. Vertex 0 is also kept in a register.
// A query runs up to two fan-edge tests, a binary search over the fan and one
// final edge test. Each orientation test is one memory read and two passes
// through the single 32x32 multiplier, then a 64-bit compare.
// in_chan.ready is low while a query is in work.
// The result sits in an output register; a query may be taken while it
// waits, and the next result holds back until out_chan takes the previous.
// Synchronous active-low reset returns to idle, empties the output register
// and sets the vertex count to 3; the vertex memory is not cleared.
`include "assert_macros.svh"

module point_in_convex_polygon #(
  parameter int MAX_VERTICES = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [pipc_pkg::CFG_W-1:0]  cfg_wdata,
  pipc_in_if.sink                     in_chan,
  pipc_out_if.source                  out_chan
);
  import pipc_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int SUM_W = IDX_W + 1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_T1_GO,
    ST_T1_WAIT,
    ST_T2_GO,
    ST_T2_WAIT,
    ST_SRCH_GO,
    ST_SRCH_WAIT,
    ST_EDGE_A,
    ST_EDGE_GO,
    ST_EDGE_WAIT,
    ST_FIN
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [LOC_W-1:0]  out_loc_r, out_loc_nxt;
  logic [LOC_W-1:0]  loc_r, loc_nxt;
  vert_t             q_r, q_nxt;
  vert_t             v0_r, v0_nxt;
  vert_t             ea_r, ea_nxt;
  logic [IDX_W-1:0]  lo_r, lo_nxt;
  logic [IDX_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic [IDX_W-1:0]  best_r, best_nxt;

  logic              in_acc, load_acc, query_acc, load_ok;
  vert_t             in_vert;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  vert_t             rd_data;
  logic              o_start;
  vert_t             o_a;
  orient_res_t       ores;
  logic [IDX_W-1:0]  n_m1, n_m2;
  logic [31:0]       cfg_wide;
  logic              ge;
  logic [IDX_W-1:0]  lo_p, hi_n, mid_p, mid_n;
  logic [SUM_W-1:0]  sum_p, sum_n;
  logic              cont_p, cont_n;

  assign in_chan.ready    = (state_r == ST_IDLE);
  assign in_acc           = in_chan.valid && in_chan.ready;
  assign load_acc         = in_acc && (in_chan.operation == OP_LOAD);
  assign query_acc        = in_acc && (in_chan.operation == OP_QUERY);
  assign load_ok          = 32'(in_chan.vertex_index) < 32'(MAX_VERTICES);
  assign in_vert.x        = in_chan.x_coord;
  assign in_vert.y        = in_chan.y_coord;
  assign wr_en            = load_acc && load_ok;
  assign wr_addr          = IDX_W'(32'(in_chan.vertex_index));

  assign out_chan.valid    = out_valid_r;
  assign out_chan.location = out_loc_r;

  assign n_m1     = IDX_W'(n_r - CNT_W'(1));
  assign n_m2     = IDX_W'(n_r - CNT_W'(2));
  assign cfg_wide = 32'(cfg_wdata);

  // both search outcomes prepared ahead, picked by the orientation sign
  assign ge     = ores.pos || ores.zero;
  assign lo_p   = mid_r + IDX_W'(1);
  assign hi_n   = mid_r - IDX_W'(1);
  assign sum_p  = SUM_W'(lo_p) + SUM_W'(hi_r);
  assign sum_n  = SUM_W'(lo_r) + SUM_W'(hi_n);
  assign mid_p  = IDX_W'(sum_p >> 1);
  assign mid_n  = IDX_W'(sum_n >> 1);
  assign cont_p = (lo_p <= hi_r);
  assign cont_n = (lo_r <= hi_n);

  assign o_start = (state_r == ST_T1_GO) || (state_r == ST_T2_GO) ||
                   (state_r == ST_SRCH_GO) || (state_r == ST_EDGE_GO);
  assign o_a     = (state_r == ST_EDGE_GO) ? ea_r : v0_r;

  pipc_vstore #(
    .DEPTH (MAX_VERTICES)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_vert),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  pipc_orient u_orient (
    .clk   (clk),
    .rst_n (rst_n),
    .start (o_start),
    .a     (o_a),
    .b     (rd_data),
    .p     (q_r),
    .res   (ores)
  );

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_loc_nxt   = out_loc_r;
    loc_nxt       = loc_r;
    q_nxt         = q_r;
    v0_nxt        = v0_r;
    ea_nxt        = ea_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    best_nxt      = best_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    if (cfg_we) begin
      if (cfg_wide < 32'(MIN_VERTICES)) begin
        n_nxt = CNT_W'(MIN_VERTICES);
      end else if (cfg_wide > 32'(MAX_VERTICES)) begin
        n_nxt = CNT_W'(MAX_VERTICES);
      end else begin
        n_nxt = CNT_W'(cfg_wide);
      end
    end

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (wr_en && (in_chan.vertex_index == '0)) begin
          v0_nxt = in_vert;
        end
        if (query_acc) begin
          q_nxt     = in_vert;
          rd_en     = 1'b1;
          rd_addr   = IDX_W'(1);
          state_nxt = ST_T1_GO;
        end
      end
      ST_T1_GO: state_nxt = ST_T1_WAIT;
      ST_T1_WAIT: begin
        if (ores.done) begin
          if (ores.zero) begin
            loc_nxt   = ores.in_box ? LOC_BOUNDARY : LOC_OUTSIDE;
            state_nxt = ST_FIN;
          end else if (!ores.pos) begin
            loc_nxt   = LOC_OUTSIDE;
            state_nxt = ST_FIN;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = n_m1;
            state_nxt = ST_T2_GO;
          end
        end
      end
      ST_T2_GO: state_nxt = ST_T2_WAIT;
      ST_T2_WAIT: begin
        if (ores.done) begin
          if (ores.zero) begin
            loc_nxt   = ores.in_box ? LOC_BOUNDARY : LOC_OUTSIDE;
            state_nxt = ST_FIN;
          end else if (ores.pos) begin
            loc_nxt   = LOC_OUTSIDE;
            state_nxt = ST_FIN;
          end else begin
            lo_nxt    = IDX_W'(1);
            hi_nxt    = n_m2;
            best_nxt  = IDX_W'(1);
            mid_nxt   = n_m1 >> 1;
            rd_en     = 1'b1;
            rd_addr   = n_m1 >> 1;
            state_nxt = ST_SRCH_GO;
          end
        end
      end
      ST_SRCH_GO: state_nxt = ST_SRCH_WAIT;
      ST_SRCH_WAIT: begin
        if (ores.done) begin
          lo_nxt   = ge ? lo_p : lo_r;
          hi_nxt   = ge ? hi_r : hi_n;
          best_nxt = ge ? mid_r : best_r;
          rd_en    = 1'b1;
          if (ge ? cont_p : cont_n) begin
            mid_nxt   = ge ? mid_p : mid_n;
            rd_addr   = ge ? mid_p : mid_n;
            state_nxt = ST_SRCH_GO;
          end else begin
            rd_addr   = ge ? mid_r : best_r;
            state_nxt = ST_EDGE_A;
          end
        end
      end
      ST_EDGE_A: begin
        ea_nxt    = rd_data;
        rd_en     = 1'b1;
        rd_addr   = best_r + IDX_W'(1);
        state_nxt = ST_EDGE_GO;
      end
      ST_EDGE_GO: state_nxt = ST_EDGE_WAIT;
      ST_EDGE_WAIT: begin
        if (ores.done) begin
          loc_nxt   = ores.zero ? LOC_BOUNDARY : (ores.pos ? LOC_INSIDE : LOC_OUTSIDE);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_loc_nxt   = loc_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      n_r         <= CNT_W'(MIN_VERTICES);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
      out_loc_r   <= out_loc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    loc_r  <= loc_nxt;
    q_r    <= q_nxt;
    v0_r   <= v0_nxt;
    ea_r   <= ea_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    mid_r  <= mid_nxt;
    best_r <= best_nxt;
  end

  `PIPC_ASSERT_RST(a_reset_idle, clk, !rst_n |=> (state_r == ST_IDLE) && !out_valid_r, "reset did not idle the block")
  `PIPC_ASSERT(a_cnt_range, clk, rst_n, (32'(n_r) >= 32'(MIN_VERTICES)) && (32'(n_r) <= 32'(MAX_VERTICES)), "vertex count out of range")
  `PIPC_ASSERT(a_mid_range, clk, rst_n, (state_r == ST_SRCH_GO) |-> (mid_r >= IDX_W'(1)) && (mid_r <= n_m2), "search probe outside fan")
  `PIPC_ASSERT(a_best_range, clk, rst_n, (state_r == ST_EDGE_A) |-> (best_r >= IDX_W'(1)) && (best_r <= n_m2), "wedge index outside fan")
  `PIPC_ASSERT(a_done_wait, clk, rst_n, ores.done |-> (state_r == ST_T1_WAIT) || (state_r == ST_T2_WAIT) || (state_r == ST_SRCH_WAIT) || (state_r == ST_EDGE_WAIT), "orientation result outside wait state")
  `PIPC_ASSERT(a_res_hold, clk, rst_n, (state_r == ST_FIN) && out_valid_r && !out_chan.ready |=> (state_r == ST_FIN) && $stable(loc_r), "pending result lost while output stalled")

endmodule
